// ===== rtl/ysd_pkg.sv =====
// ----------------------------------------------------------------------------
// ysd_pkg
// Shared types, constants and helpers for the yEnc stream decoder.
// ----------------------------------------------------------------------------
package ysd_pkg;

  // Parser states
  typedef enum logic [4:0] {
    P_LINE, P_DOT, P_ENDM, P_Y, P_YKEY, P_DATA, P_ESC, P_STALL,
    P_BEGIN_KEYS, P_BEGIN_PART, P_BEGIN_LINE, P_BEGIN_SIZE, P_BEGIN_NAME,
    P_PART_KEYS, P_PART_BEGIN, P_PART_END,
    P_END_KEYS, P_END_SIZE, P_END_PART, P_END_PCRC, P_END_CRC
  } pstate_e;

  // Outcome of one byte inside a numeric field
  typedef enum logic [1:0] {
    DG_ACC,
    DG_BACK,
    DG_LINE
  } digit_e;

  // Keyword table indexes
  localparam int unsigned KW_NUM   = 11;
  localparam int unsigned K_YBEGIN = 0;
  localparam int unsigned K_PART   = 1;
  localparam int unsigned K_LINE   = 2;
  localparam int unsigned K_SIZE   = 3;
  localparam int unsigned K_NAME   = 4;
  localparam int unsigned K_YPART  = 5;
  localparam int unsigned K_BEGIN  = 6;
  localparam int unsigned K_END    = 7;
  localparam int unsigned K_YEND   = 8;
  localparam int unsigned K_PCRC   = 9;
  localparam int unsigned K_CRC    = 10;

  // Keyword text, right aligned, and length in bytes
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    "=ybegin ", "part=", "line=", "size=", "name=", "=ypart ",
    "begin=", "end=", "=yend ", "pcrc32=", "crc32="
  };
  localparam int unsigned KW_LEN [KW_NUM] = '{8, 5, 5, 5, 5, 7, 6, 4, 6, 7, 6};

  // Characters
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_Y   = 8'h79;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Decode offsets: plain data and escaped data (42 + 64)
  localparam logic [7:0] DATA_OFFSET = 8'd42;
  localparam logic [7:0] ESC_OFFSET  = 8'd106;

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // crc_status codes
  localparam logic [1:0] CRC_NONE  = 2'd0;
  localparam logic [1:0] CRC_MATCH = 2'd1;
  localparam logic [1:0] CRC_BAD   = 2'd2;

  localparam logic [23:0] CAP_RESET = 24'd1048576;

  // Queue between parser and output stage
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QLW    = $clog2(QDEPTH + 1);

  // One parsed request, as handed to the output stage
  typedef struct packed {
    logic        emit;
    logic [7:0]  dbyte;
    logic [23:0] position;
    logic        eom;
    logic        trailer;
    logic        rdy;
    logic [31:0] line_len;
    logic [31:0] size_len;
    logic [31:0] pbegin;
    logic [31:0] pend;
    logic        have_pcrc;
    logic        have_fcrc;
    logic [31:0] pcrc;
    logic [31:0] fcrc;
  } ysd_rec_t;

  // Queue status
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QLW-1:0] level;
  } ysd_qstat_t;

  // Character j of keyword k
  function automatic logic [7:0] kw_char(int unsigned k, logic [2:0] j);
    logic [63:0] t;
    t = KW_TEXT[k] << {j, 3'b000};
    return t[8*KW_LEN[k]-1 -: 8];
  endfunction

  // Advance the CRC over one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ysd_parser.sv =====
// ----------------------------------------------------------------------------
// ysd_parser
// Front end: parses header/trailer lines, undoes dot-stuffing and yEnc coding.
// ----------------------------------------------------------------------------
module ysd_parser import ysd_pkg::*; #(
  parameter int unsigned NAME_BYTES    = 256,
  parameter int unsigned KEYWORD_BYTES = 16,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  in_byte_i,
  input  logic [23:0] capacity_i,
  output ysd_rec_t    rec_o
);

  localparam int unsigned KCW = $clog2(KEYWORD_BYTES + 1);
  localparam int unsigned NCW = $clog2(NAME_BYTES);

  pstate_e                  state_q, state_d;
  logic [KCW-1:0]           kcnt_q, kcnt_d;
  logic [KW_NUM-1:0]        kmatch_q, kmatch_d;
  logic [NCW-1:0]           ncnt_q, ncnt_d;
  logic                     name0_q, name0_d;
  logic                     nonblank_q, nonblank_d;
  logic [31:0]              lp_q, lp_d;
  logic [POSITION_BITS-1:0] ecnt_q, ecnt_d;
  logic [31:0]              line_q, line_d, size_q, size_d;
  logic [31:0]              begin_q, begin_d, end_q, end_d;
  logic [31:0]              pcrc_q, pcrc_d, fcrc_q, fcrc_d;
  logic                     hp_q, hp_d, hf_q, hf_d;
  logic                     eom_q, eom_d, trl_q, trl_d;

  logic [7:0]        a;
  logic              a_eol, a_blank, a_digit, a_hex;
  logic [3:0]        a_dval, a_hval;
  logic [KCW-1:0]    kbase;
  logic [KW_NUM-1:0] k_hit, k_eol, k_full;
  logic              kw_eol, kw_more;
  logic              rdy_old, ok;
  logic [31:0]       lp_p1;
  logic              ge_q, ge_p1;
  logic              emit_req, emit;
  logic [7:0]        emit_val, ebyte;
  logic [31:0]       dec_line, dec_size, dec_begin, dec_end;
  digit_e            dg;

  // Byte classes
  always_comb begin
    a       = in_byte_i;
    a_eol   = (a == CH_CR) || (a == CH_LF);
    a_blank = (a == CH_SP) || (a == CH_TAB);
    a_digit = (a >= 8'h30) && (a <= 8'h39);
    a_dval  = 4'(a - 8'h30);
    a_hex   = a_digit || ((a >= 8'h41) && (a <= 8'h46)) || ((a >= 8'h61) && (a <= 8'h66));
    a_hval  = a_digit ? a_dval :
              (a <= 8'h46) ? 4'(a - 8'h37) : 4'(a - 8'h57);
    dg      = a_digit ? DG_ACC : (a_blank ? DG_BACK : DG_LINE);
  end

  // Decimal accumulate (times ten by shift and add)
  always_comb begin
    dec_line  = (line_q << 3) + (line_q << 1) + {28'd0, a_dval};
    dec_size  = (size_q << 3) + (size_q << 1) + {28'd0, a_dval};
    dec_begin = (begin_q << 3) + (begin_q << 1) + {28'd0, a_dval};
    dec_end   = (end_q << 3) + (end_q << 1) + {28'd0, a_dval};
  end

  // Incremental keyword match against every table entry
  always_comb begin
    kbase = ((state_q == P_LINE) || (kcnt_q >= KCW'(KEYWORD_BYTES))) ? '0 : kcnt_q;
    for (int k = 0; k < KW_NUM; k++) begin
      logic prev, lt;
      prev      = (kbase == '0) ? 1'b1 : kmatch_q[k];
      lt        = (32'(kbase) < KW_LEN[k]);
      k_hit[k]  = prev && lt && (a == kw_char(k, kbase[2:0]));
      k_eol[k]  = prev && lt && a_eol;
      k_full[k] = k_hit[k] && (32'(kbase) + 32'd1 == KW_LEN[k]);
    end
    kw_eol  = |k_eol;
    kw_more = |k_hit;
  end

  // Emission gate and line position compares
  always_comb begin
    rdy_old = (line_q != '0) && (size_q != '0) && name0_q;
    ok      = !trl_q && (32'(ecnt_q) < 32'(capacity_i)) && (ecnt_q != '1);
    lp_p1   = lp_q + 32'd1;
    ge_q    = (lp_q >= line_q);
    ge_p1   = (lp_p1 >= line_q);
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    kcnt_d     = kcnt_q;
    kmatch_d   = kmatch_q;
    ncnt_d     = ncnt_q;
    name0_d    = name0_q;
    nonblank_d = nonblank_q;
    lp_d       = lp_q;
    ecnt_d     = ecnt_q;
    line_d     = line_q;
    size_d     = size_q;
    begin_d    = begin_q;
    end_d      = end_q;
    pcrc_d     = pcrc_q;
    fcrc_d     = fcrc_q;
    hp_d       = hp_q;
    hf_d       = hf_q;
    eom_d      = eom_q;
    trl_d      = trl_q;
    emit_req   = 1'b0;
    emit_val   = a - DATA_OFFSET;

    case (state_q)
      P_DOT: begin
        if (a == CH_DOT) begin
          emit_req = 1'b1;
          state_d  = P_DATA;
        end else if (a == CH_CR) begin
          state_d = P_ENDM;
        end else begin
          state_d = P_LINE;
        end
      end
      P_ENDM: begin
        if (a == CH_LF) eom_d = 1'b1;
        state_d = P_LINE;
      end
      P_Y: begin
        if (a == CH_Y) begin
          state_d  = P_YKEY;
          kcnt_d   = kbase + 1'b1;
          kmatch_d = k_hit;
        end else if (rdy_old) begin
          emit_req = 1'b1;
          emit_val = a - ESC_OFFSET;
          state_d  = P_DATA;
        end else begin
          state_d = P_LINE;
        end
      end
      P_YKEY: begin
        kcnt_d   = kbase + 1'b1;
        kmatch_d = k_hit;
        if (kw_eol) begin
          state_d = P_LINE;
        end else if (k_full[K_YBEGIN]) begin
          state_d = P_BEGIN_KEYS;
          kcnt_d  = '0;
        end else if (k_full[K_YPART]) begin
          state_d = P_PART_KEYS;
          kcnt_d  = '0;
        end else if (k_full[K_YEND]) begin
          state_d = P_END_KEYS;
          kcnt_d  = '0;
        end else if (!kw_more || (|k_full)) begin
          kcnt_d = '0;
        end
      end
      P_DATA: begin
        if (!rdy_old) begin
          state_d = P_LINE;
        end else if (a == CH_EQ) begin
          lp_d    = lp_p1;
          state_d = ge_p1 ? P_STALL : P_ESC;
        end else if (a_eol) begin
          state_d = P_LINE;
        end else begin
          emit_req = 1'b1;
          state_d  = (ge_q || (ok ? ge_p1 : ge_q)) ? P_LINE : P_DATA;
        end
      end
      P_ESC: begin
        if (!ge_q) begin
          emit_req = 1'b1;
          emit_val = a - ESC_OFFSET;
          state_d  = (ok && ge_p1) ? P_LINE : P_DATA;
        end else begin
          state_d = P_STALL;
        end
      end
      P_STALL: begin
        if (a_eol) begin
          lp_d = '0;
        end else if (a != CH_Y) begin
          emit_req = 1'b1;
          emit_val = a - ESC_OFFSET;
          state_d  = P_DATA;
          lp_d     = lp_p1;
        end else begin
          state_d = P_LINE;
        end
      end
      P_BEGIN_KEYS: begin
        eom_d    = 1'b0;
        trl_d    = 1'b0;
        kcnt_d   = kbase + 1'b1;
        kmatch_d = k_hit;
        if (kw_eol) begin
          state_d = P_LINE;
        end else if (k_full[K_PART]) begin
          state_d = P_BEGIN_PART;
        end else if (k_full[K_LINE]) begin
          line_d  = '0;
          state_d = P_BEGIN_LINE;
        end else if (k_full[K_SIZE]) begin
          size_d  = '0;
          state_d = P_BEGIN_SIZE;
        end else if (k_full[K_NAME]) begin
          ncnt_d     = '0;
          name0_d    = 1'b0;
          nonblank_d = 1'b0;
          state_d    = P_BEGIN_NAME;
        end else if (|k_full) begin
          state_d = P_LINE;
        end else if (!kw_more) begin
          kcnt_d = '0;
        end
      end
      P_BEGIN_PART, P_END_PART, P_END_SIZE: begin
        // values of these fields are never reported; only the flow matters
        kcnt_d = '0;
        if (dg == DG_BACK) begin
          state_d = (state_q == P_BEGIN_PART) ? P_BEGIN_KEYS : P_END_KEYS;
        end else if (dg == DG_LINE) begin
          state_d = P_LINE;
        end
      end
      P_BEGIN_LINE, P_BEGIN_SIZE, P_PART_BEGIN, P_PART_END: begin
        kcnt_d = '0;
        case (dg)
          DG_ACC: begin
            case (state_q)
              P_BEGIN_LINE: line_d  = dec_line;
              P_BEGIN_SIZE: size_d  = dec_size;
              P_PART_BEGIN: begin_d = dec_begin;
              default:      end_d   = dec_end;
            endcase
          end
          DG_BACK: begin
            state_d = ((state_q == P_PART_BEGIN) || (state_q == P_PART_END)) ?
                      P_PART_KEYS : P_BEGIN_KEYS;
          end
          default: state_d = P_LINE;
        endcase
      end
      P_BEGIN_NAME: begin
        kcnt_d = '0;
        // closing a name: an all-blank name becomes empty, any other counts as present
        if (ncnt_q >= NCW'(NAME_BYTES - 1)) begin
          name0_d = nonblank_q;
          state_d = P_BEGIN_KEYS;
        end else if (a_eol || (a == CH_NUL)) begin
          ncnt_d  = ncnt_q + 1'b1;
          name0_d = nonblank_q;
          state_d = P_LINE;
        end else begin
          ncnt_d     = ncnt_q + 1'b1;
          name0_d    = 1'b1;
          nonblank_d = nonblank_q | !a_blank;
        end
      end
      P_PART_KEYS: begin
        kcnt_d   = kbase + 1'b1;
        kmatch_d = k_hit;
        if (kw_eol) begin
          state_d = P_LINE;
        end else if (k_full[K_BEGIN]) begin
          begin_d = '0;
          state_d = P_PART_BEGIN;
        end else if (k_full[K_END]) begin
          end_d   = '0;
          state_d = P_PART_END;
        end else if (|k_full) begin
          state_d = P_LINE;
        end else if (!kw_more) begin
          kcnt_d = '0;
        end
      end
      P_END_KEYS: begin
        trl_d    = 1'b1;
        kcnt_d   = kbase + 1'b1;
        kmatch_d = k_hit;
        if (kw_eol) begin
          state_d = P_LINE;
        end else if (k_full[K_PART]) begin
          state_d = P_END_PART;
        end else if (k_full[K_SIZE]) begin
          state_d = P_END_SIZE;
        end else if (k_full[K_CRC]) begin
          fcrc_d  = '0;
          state_d = P_END_CRC;
        end else if (k_full[K_PCRC]) begin
          pcrc_d  = '0;
          state_d = P_END_PCRC;
        end else if (|k_full) begin
          state_d = P_LINE;
        end else if (!kw_more) begin
          kcnt_d = '0;
        end
      end
      P_END_CRC, P_END_PCRC: begin
        kcnt_d = '0;
        if (state_q == P_END_CRC) hf_d = 1'b1;
        else                      hp_d = 1'b1;
        if (a_hex) begin
          if (state_q == P_END_CRC) fcrc_d = {fcrc_q[27:0], a_hval};
          else                      pcrc_d = {pcrc_q[27:0], a_hval};
        end else if (a_blank) begin
          state_d = P_END_KEYS;
        end else begin
          state_d = P_LINE;
        end
      end
      default: begin
        // start of line
        lp_d = '0;
        if (a == CH_EQ) begin
          kcnt_d   = kbase + 1'b1;
          kmatch_d = k_hit;
          state_d  = P_Y;
          lp_d     = 32'd1;
        end else if (a == CH_DOT) begin
          state_d = P_DOT;
        end else if (a_eol) begin
          state_d = P_LINE;
        end else if (rdy_old) begin
          emit_req = 1'b1;
          state_d  = P_DATA;
        end else begin
          state_d = P_LINE;
        end
      end
    endcase

    // Emit when below capacity and before the trailer
    emit  = emit_req && ok;
    ebyte = emit ? emit_val : 8'd0;
    if (emit) begin
      ecnt_d = ecnt_q + 1'b1;
      lp_d   = lp_d + 32'd1;
    end

    if (kcnt_d >= KCW'(KEYWORD_BYTES)) kcnt_d = '0;
  end

  // Request to the queue
  always_comb begin
    rec_o.emit      = emit;
    rec_o.dbyte     = ebyte;
    rec_o.position  = 24'(ecnt_d);
    rec_o.eom       = eom_d;
    rec_o.trailer   = trl_d;
    rec_o.rdy       = (line_d != '0) && (size_d != '0) && name0_d;
    rec_o.line_len  = line_d;
    rec_o.size_len  = size_d;
    rec_o.pbegin    = begin_d;
    rec_o.pend      = end_d;
    rec_o.have_pcrc = hp_d;
    rec_o.have_fcrc = hf_d;
    rec_o.pcrc      = pcrc_d;
    rec_o.fcrc      = fcrc_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= P_LINE;
      kcnt_q     <= '0;
      kmatch_q   <= '0;
      ncnt_q     <= '0;
      name0_q    <= 1'b0;
      nonblank_q <= 1'b0;
      lp_q       <= '0;
      ecnt_q     <= '0;
      line_q     <= '0;
      size_q     <= '0;
      begin_q    <= '0;
      end_q      <= '0;
      pcrc_q     <= '0;
      fcrc_q     <= '0;
      hp_q       <= 1'b0;
      hf_q       <= 1'b0;
      eom_q      <= 1'b0;
      trl_q      <= 1'b0;
    end else if (fire_i) begin
      state_q    <= state_d;
      kcnt_q     <= kcnt_d;
      kmatch_q   <= kmatch_d;
      ncnt_q     <= ncnt_d;
      name0_q    <= name0_d;
      nonblank_q <= nonblank_d;
      lp_q       <= lp_d;
      ecnt_q     <= ecnt_d;
      line_q     <= line_d;
      size_q     <= size_d;
      begin_q    <= begin_d;
      end_q      <= end_d;
      pcrc_q     <= pcrc_d;
      fcrc_q     <= fcrc_d;
      hp_q       <= hp_d;
      hf_q       <= hf_d;
      eom_q      <= eom_d;
      trl_q      <= trl_d;
    end
  end

endmodule

// ===== rtl/ysd_fifo.sv =====
// ----------------------------------------------------------------------------
// ysd_fifo
// Short request queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module ysd_fifo import ysd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ysd_rec_t   rec_i,
  input  logic       pop_i,
  output ysd_rec_t   rec_o,
  output ysd_qstat_t stat_o
);

  ysd_rec_t       mem_q [QDEPTH];
  logic [QPW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QLW-1:0] level_q, level_d;

  // Pointer and level update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    level_d = level_q;
    if (push_i) begin
      wptr_d = (32'(wptr_q) == QDEPTH - 1) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (32'(rptr_q) == QDEPTH - 1) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i)      level_d = level_q + 1'b1;
    else if (pop_i && !push_i) level_d = level_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= rec_i;
  end

  assign rec_o        = mem_q[rptr_q];
  assign stat_o.full  = (level_q == QLW'(QDEPTH));
  assign stat_o.empty = (level_q == '0);
  assign stat_o.level = level_q;

endmodule

// ===== rtl/ysd_back.sv =====
// ----------------------------------------------------------------------------
// ysd_back
// Back end: running CRC-32 over emitted bytes and the result register.
// ----------------------------------------------------------------------------
module ysd_back import ysd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ysd_qstat_t qstat_i,
  input  ysd_rec_t   rec_i,
  output logic       pop_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output ysd_rec_t   out_rec_o,
  output logic [1:0] crc_status_o
);

  logic [31:0] crc_q, crc_d, fin;
  logic        valid_q, valid_d;
  ysd_rec_t    rec_q;
  logic [1:0]  status_q, status_d;

  // Take a request when the result register is free or being drained
  assign pop_o = !qstat_i.empty && (!valid_q || out_ready_i);

  // CRC update and match check
  always_comb begin
    crc_d = rec_i.emit ? crc32_byte(crc_q, rec_i.dbyte) : crc_q;
    fin   = crc_d ^ CRC_INIT;
    if (!rec_i.have_pcrc && !rec_i.have_fcrc) begin
      status_d = CRC_NONE;
    end else if ((rec_i.have_pcrc && (fin != rec_i.pcrc)) ||
                 (rec_i.have_fcrc && (fin != rec_i.fcrc))) begin
      status_d = CRC_BAD;
    end else begin
      status_d = CRC_MATCH;
    end
    valid_d = pop_o ? 1'b1 : (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) crc_q <= crc_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q    <= rec_i;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_rec_o    = rec_q;
  assign crc_status_o = status_q;

endmodule

// ===== rtl/yenc_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// yenc_stream_decoder
// Byte-serial yEnc article decoder with running CRC-32.
// ----------------------------------------------------------------------------
// Takes one article byte per cycle while the queue is not full and returns
// one result per byte, through the queue and then the result register. The
// rate is set by the parser, which updates its line state and keyword
// matches as each byte is accepted; a two-entry queue and a result register
// let the input and output sides stall independently. out_capacity may only
// be written while no request is in flight.
module yenc_stream_decoder import ysd_pkg::*; #(
  parameter int unsigned NAME_BYTES    = 256,
  parameter int unsigned KEYWORD_BYTES = 16,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_capacity_we_i,
  input  logic [23:0] out_capacity_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic [23:0] out_position_o,
  output logic        end_of_message_o,
  output logic        trailer_seen_o,
  output logic        decoder_ready_o,
  output logic [31:0] line_length_o,
  output logic [31:0] declared_size_o,
  output logic [31:0] part_begin_o,
  output logic [31:0] part_end_o,
  output logic [1:0]  crc_status_o
);

  logic [23:0] cap_q;
  logic        fire, pop;
  ysd_rec_t    front_rec, q_rec, out_rec;
  ysd_qstat_t  qstat;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CAP_RESET;
    else if (out_capacity_we_i) cap_q <= out_capacity_i;
  end

  assign in_ready_o = !qstat.full;
  assign fire       = in_valid_i && in_ready_o;

  ysd_parser #(
    .NAME_BYTES    (NAME_BYTES),
    .KEYWORD_BYTES (KEYWORD_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .in_byte_i  (in_byte_i),
    .capacity_i (cap_q),
    .rec_o      (front_rec)
  );

  ysd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .rec_i  (front_rec),
    .pop_i  (pop),
    .rec_o  (q_rec),
    .stat_o (qstat)
  );

  ysd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qstat_i      (qstat),
    .rec_i        (q_rec),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_rec_o    (out_rec),
    .crc_status_o (crc_status_o)
  );

  // Result fields
  assign data_valid_o     = out_rec.emit;
  assign data_byte_o      = out_rec.dbyte;
  assign out_position_o   = out_rec.position;
  assign end_of_message_o = out_rec.eom;
  assign trailer_seen_o   = out_rec.trailer;
  assign decoder_ready_o  = out_rec.rdy;
  assign line_length_o    = out_rec.line_len;
  assign declared_size_o  = out_rec.size_len;
  assign part_begin_o     = out_rec.pbegin;
  assign part_end_o       = out_rec.pend;

`ifndef SYNTHESIS
  // an emitted byte always advances the position past zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> out_position_o != 24'd0)
    else $error("emitted byte with zero position");

  // queue level never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qstat.level) <= QDEPTH)
    else $error("queue overflow");

  // a popped request is presented in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("popped request not presented");
`endif

endmodule
